// File: hdl/stab_pkg.sv
// Shared types and constants for the sorted table search block.
package stab_pkg;

    // Fixed field widths of the request and result items
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 4;
    localparam int KEY_W    = 16;

    // Request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_BSEARCH = 2'd1,
        OP_ISEARCH = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    // Table read address source
    typedef enum logic [1:0] {
        RD_L    = 2'd0,
        RD_R    = 2'd1,
        RD_BMID = 2'd2,
        RD_IMID = 2'd3
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    wr_en;
        logic    init;
        logic    probe;
        rd_sel_t rd_sel;
        logic    m_load;
        logic    save_al;
        logic    save_ar;
        logic    mul;
        logic    div_step;
        logic    narrow;
        logic    hit;
        logic    miss;
        logic    out_load;
    } stab_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic can_probe;
        logic bad_interp;
        logic div_done;
        logic m_out_range;
        logic key_eq;
    } stab_status_t;

endpackage

// File: hdl/stab_ctrl.sv
// Search sequencer: accepts requests and steps the datapath through the probes.
module stab_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  stab_pkg::opcode_t      opcode,
    output logic                   s_ready,
    input  logic                   m_ready,
    output logic                   m_valid,
    input  stab_pkg::stab_status_t status,
    output stab_pkg::stab_cmd_t    cmd
);
    import stab_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOP, S_RDL, S_RDR, S_MUL, S_DIV, S_QCHK, S_CMP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   interp_reg, interp_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        interp_next = interp_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_L;
        s_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (opcode) inside
                        OP_WRITE: cmd.wr_en = 1'b1;
                        OP_BSEARCH, OP_ISEARCH: begin
                            cmd.init    = 1'b1;
                            interp_next = (opcode == OP_ISEARCH);
                            state_next  = S_LOOP;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOOP: begin
                if (!status.can_probe) begin
                    cmd.miss   = 1'b1;
                    state_next = S_DONE;
                end else if (interp_reg) begin
                    cmd.probe  = 1'b1;
                    cmd.rd_sel = RD_L;
                    state_next = S_RDL;
                end else begin
                    cmd.probe  = 1'b1;
                    cmd.rd_sel = RD_BMID;
                    cmd.m_load = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_RDL: begin
                cmd.save_al = 1'b1;
                cmd.rd_sel  = RD_R;
                state_next  = S_RDR;
            end
            S_RDR: begin
                cmd.save_ar = 1'b1;
                if (status.bad_interp) begin
                    cmd.miss   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (status.div_done) begin
                    state_next = S_QCHK;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_QCHK: begin
                if (status.m_out_range) begin
                    cmd.miss   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.rd_sel = RD_IMID;
                    cmd.m_load = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                if (status.key_eq) begin
                    cmd.hit    = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.narrow = 1'b1;
                    state_next = S_LOOP;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Result valid flag
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            interp_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            interp_reg  <= interp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hdl/stab_dpath.sv
// Search datapath: table memory, bounds, interpolation multiply and divider.
module stab_dpath #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [stab_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [stab_pkg::KEY_W-1:0]    data_value,
    input  stab_pkg::stab_cmd_t                  cmd,
    output stab_pkg::stab_status_t               status,
    output logic                                 found,
    output logic [stab_pkg::INDEX_W-1:0]         found_index,
    output logic signed [stab_pkg::KEY_W-1:0]    found_value
);
    import stab_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int LW = IW + 2;
    localparam int PW = $clog2(TABLE_DEPTH + 1);
    localparam int W  = ((VALUE_WIDTH > KEY_W) ? VALUE_WIDTH : KEY_W) + 1;
    localparam int NW = W + IW;
    localparam int CW = $clog2(NW + 1);
    localparam int MW = NW + 2;

    // Table storage and registered read
    logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
    logic signed [VALUE_WIDTH-1:0] rdata_reg;
    logic [IW-1:0]                 raddr;
    logic [IW+INDEX_W-1:0]         widx;
    logic                          wr_ok;

    // Search registers
    logic signed [KEY_W-1:0]       key_reg;
    logic signed [LW-1:0]          l_reg, r_reg;
    logic [IW-1:0]                 m_reg;
    logic [PW-1:0]                 probes_reg;
    logic signed [VALUE_WIDTH-1:0] al_reg;
    logic                          den_neg_reg;
    logic [W-1:0]                  den_mag_reg;
    logic [W-1:0]                  rem_reg;
    logic [NW-1:0]                 quo_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          res_found_reg;
    logic [INDEX_W-1:0]            res_index_reg;
    logic signed [KEY_W-1:0]       res_value_reg;
    logic                          out_found_reg;
    logic [INDEX_W-1:0]            out_index_reg;
    logic signed [KEY_W-1:0]       out_value_reg;

    logic signed [W-1:0]           key_w, al_w, rd_w, diff_w, den_w;
    logic signed [LW-1:0]          sum_lr, span, m_ext;
    logic [IW-1:0]                 bmid;
    logic [W:0]                    trial;
    logic                          ge;
    logic signed [MW-1:0]          lx, qx, m_wide;
    logic [IW+INDEX_W-1:0]         m_idx;

    assign widx  = (IW + INDEX_W)'(entry_index);
    assign wr_ok = ((IW + INDEX_W + 1)'(entry_index) < (IW + INDEX_W + 1)'(TABLE_DEPTH));

    // Signed compare operands at a common width
    assign key_w  = W'(key_reg);
    assign al_w   = W'(al_reg);
    assign rd_w   = W'(rdata_reg);
    assign diff_w = key_w - al_w;
    assign den_w  = rd_w - al_w;

    // Binary midpoint and interpolation span
    assign sum_lr = l_reg + r_reg;
    assign bmid   = sum_lr[IW:1];
    assign span   = r_reg - l_reg;

    // One restoring divide step
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign ge    = (trial >= {1'b0, den_mag_reg});

    // Interpolated probe, quotient signed by the divisor
    assign lx     = MW'(l_reg);
    assign qx     = $signed({2'b00, quo_reg});
    assign m_wide = den_neg_reg ? (lx - qx) : (lx + qx);

    assign m_ext = $signed({2'b00, m_reg});
    assign m_idx = (IW + INDEX_W)'(m_reg);

    // Read address select
    always_comb begin
        case (cmd.rd_sel)
            RD_L:    raddr = l_reg[IW-1:0];
            RD_R:    raddr = r_reg[IW-1:0];
            RD_BMID: raddr = bmid;
            default: raddr = m_wide[IW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wr_ok) begin
            mem[widx[IW-1:0]] <= VALUE_WIDTH'(data_value);
        end
        rdata_reg <= mem[raddr];
    end

    // Status toward the controller
    assign status.can_probe   = (r_reg >= l_reg) && (probes_reg < PW'(TABLE_DEPTH));
    assign status.bad_interp  = (rd_w == al_w) || (key_w < al_w);
    assign status.div_done    = (cnt_reg == '0);
    assign status.m_out_range = (m_wide < 0) || (m_wide > MW'(TABLE_DEPTH - 1));
    assign status.key_eq      = (key_w == rd_w);

    // Search state
    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            key_reg    <= data_value;
            l_reg      <= '0;
            r_reg      <= LW'(TABLE_DEPTH - 1);
            probes_reg <= '0;
        end
        if (cmd.probe) begin
            probes_reg <= probes_reg + 1'b1;
        end
        if (cmd.m_load) begin
            m_reg <= raddr;
        end
        if (cmd.save_al) begin
            al_reg <= rdata_reg;
        end
        if (cmd.save_ar) begin
            den_neg_reg <= den_w[W-1];
            den_mag_reg <= den_w[W-1] ? W'(-den_w) : W'(den_w);
        end
        if (cmd.narrow) begin
            if (key_w < rd_w) begin
                r_reg <= m_ext - 1'b1;
            end else begin
                l_reg <= m_ext + 1'b1;
            end
        end
    end

    // Multiply then divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.mul) begin
            cnt_reg <= CW'(NW);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.mul) begin
            quo_reg <= NW'($unsigned(diff_w) * $unsigned(span[IW-1:0]));
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? W'(trial - {1'b0, den_mag_reg}) : trial[W-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    // Pending result and output register
    always_ff @(posedge aclk) begin
        if (cmd.hit) begin
            res_found_reg <= 1'b1;
            res_index_reg <= m_idx[INDEX_W-1:0];
            res_value_reg <= KEY_W'(rdata_reg);
        end else if (cmd.miss) begin
            res_found_reg <= 1'b0;
            res_index_reg <= '0;
            res_value_reg <= '0;
        end
        if (cmd.out_load) begin
            out_found_reg <= res_found_reg;
            out_index_reg <= res_index_reg;
            out_value_reg <= res_value_reg;
        end
    end

    assign found       = out_found_reg;
    assign found_index = out_index_reg;
    assign found_value = out_value_reg;

endmodule

// File: hdl/sorted_table_search.sv
// Top level: sorted table with binary and interpolation search.
// Write request: no result; the next request is taken the following cycle.
// Binary search: each probe steps S_LOOP then S_CMP, up to clog2(TABLE_DEPTH)+1 probes, then S_DONE.
// Interpolation: each probe reads both ends, multiplies and divides to an NW-bit quotient
//   (NW = max(VALUE_WIDTH,16)+1+clog2(TABLE_DEPTH)), one bit per cycle; up to TABLE_DEPTH probes.
// Reset: synchronous active low, clears control; table contents undefined until written.
module sorted_table_search #(
    parameter int TABLE_DEPTH = 16,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], entry_index[5:2], data_value[21:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // found[0], found_index[4:1], found_value[20:5]
);
    import stab_pkg::*;

    stab_cmd_t               cmd;
    stab_status_t            status;
    logic                    found;
    logic [INDEX_W-1:0]      found_index;
    logic signed [KEY_W-1:0] found_value;

    stab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .opcode  (opcode_t'(s_tdata[1:0])),
        .s_ready (s_tready),
        .m_ready (m_tready),
        .m_valid (m_tvalid),
        .status  (status),
        .cmd     (cmd)
    );

    stab_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .entry_index (s_tdata[5:2]),
        .data_value  ($signed(s_tdata[21:6])),
        .cmd         (cmd),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .found_value (found_value)
    );

    assign m_tdata = {3'b000, found_value, found_index, found};

endmodule

// File: hdl/stab_checker.sv
// Port-level checks for the sorted table search block, bound to the top level.
module stab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import stab_pkg::*;

    // Stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A miss carries zero index and value
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[20:1] == 20'd0)
        else $error("miss with nonzero payload");

    // A write request leaves the input ready in the next cycle
    a_write_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[1:0] == OP_WRITE |=> s_tready)
        else $error("write request stalled the input");

    // A search request holds off the input while it runs
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[1:0] == OP_BSEARCH || s_tdata[1:0] == OP_ISEARCH)
        |=> !s_tready)
        else $error("input ready during a search");

endmodule

bind sorted_table_search stab_checker u_stab_checker (.*);

// File: tb/sorted_table_search_tb.sv
// Testbench for sorted_table_search: directed and random searches against a behavioral predictor.
`timescale 1ns / 1ps

module sorted_table_search_tb;
    import stab_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic                    found;
        logic [INDEX_W-1:0]      idx;
        logic signed [KEY_W-1:0] value;
    } search_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // predictor state
    logic signed [KEY_W-1:0] shadow_table [DEPTH];
    search_result_t          pending_results [$];
    int                      mismatch_count = 0;
    int                      result_count = 0;
    int                      search_count = 0;
    int                      hit_count = 0;
    bit                      stall_enable = 1'b1;

    sorted_table_search u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // opcode, entry_index, data_value
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // found, found_index, found_value
    );

    always #6 aclk = ~aclk;

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // binary or interpolation search on the shadow table
    function automatic search_result_t predict_search(logic signed [KEY_W-1:0] key,
                                                      bit interp);
        longint         lo, hi, mid, al, ar, probes;
        search_result_t res;
        lo = 0;
        hi = DEPTH - 1;
        probes = 0;
        res = '0;
        while (hi >= lo && probes < DEPTH) begin
            probes++;
            if (interp) begin
                al = shadow_table[lo];
                ar = shadow_table[hi];
                if (ar == al || longint'(key) < al) return res;
                mid = lo + ((longint'(key) - al) * (hi - lo)) / (ar - al);
                if (mid >= DEPTH || mid < 0) return res;
            end else begin
                mid = (lo + hi) / 2;
            end
            if (key < shadow_table[mid]) begin
                hi = mid - 1;
            end else if (key == shadow_table[mid]) begin
                res.found = 1'b1;
                res.idx   = mid[INDEX_W-1:0];
                res.value = shadow_table[mid];
                return res;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    // send one request and record its expected result
    task automatic send_request(opcode_t op, logic [INDEX_W-1:0] idx,
                                logic signed [KEY_W-1:0] val);
        int gap;
        gap = stall_enable ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val, idx, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (op)
            OP_WRITE: begin
                shadow_table[idx] = val;
            end
            OP_BSEARCH, OP_ISEARCH: begin
                pending_results.push_back(predict_search(val, op == OP_ISEARCH));
                search_count++;
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // ascending table with random spacing; steep keeps values spread
    task automatic load_sorted(int step_max, int base);
        int v;
        v = base;
        for (int i = 0; i < DEPTH; i++) begin
            send_request(OP_WRITE, i[INDEX_W-1:0], v[KEY_W-1:0]);
            v += $urandom_range(0, step_max);
            if (v > 32767) v = 32767;
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return shadow_table[$urandom_range(0, DEPTH - 1)];
        if (roll < 8) return KEY_W'(shadow_table[$urandom_range(0, DEPTH - 1)]
                                    + $urandom_range(0, 2) - 1);
        return KEY_W'($urandom());
    endfunction

    task automatic test_extremes();
        for (int i = 0; i < DEPTH; i++)
            send_request(OP_WRITE, i[INDEX_W-1:0], (i == 0) ? -16'sd32768 :
                         (i == DEPTH - 1) ? 16'sd32767 : 16'(i * 1000 - 7000));
        send_request(OP_BSEARCH, '0, -16'sd32768);
        send_request(OP_BSEARCH, '0, 16'sd32767);
        send_request(OP_ISEARCH, '0, -16'sd32768);
        send_request(OP_ISEARCH, '0, 16'sd32767);
        send_request(OP_ISEARCH, '0, 16'sd1000);
        send_request(OP_BSEARCH, '0, 16'sd1001);
        send_request(OP_NONE, 4'hf, 16'sh5a5a);
        send_request(OP_ISEARCH, '0, -16'sd32768 + 1);
        // flat table: interpolation sees equal ends
        for (int i = 0; i < DEPTH; i++) send_request(OP_WRITE, i[INDEX_W-1:0], 16'sd5);
        send_request(OP_ISEARCH, '0, 16'sd5);
        send_request(OP_BSEARCH, '0, 16'sd5);
        drain_results();
    endtask

    task automatic test_sorted_random(int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (n % 60 == 0)
                load_sorted($urandom_range(0, 1) ? 4 : 4000,
                            $urandom_range(0, 1) ? -32768 : $urandom_range(0, 2000) - 1000);
            else if (r < 45) send_request(OP_BSEARCH, INDEX_W'($urandom()), pick_key());
            else if (r < 90) send_request(OP_ISEARCH, INDEX_W'($urandom()), pick_key());
            else if (r < 94) send_request(OP_NONE, INDEX_W'($urandom()), KEY_W'($urandom()));
            else send_request(OP_WRITE, INDEX_W'($urandom()),
                              KEY_W'($urandom()));  // may unsort table
        end
    endtask

    task automatic test_pause();
        drain_results();
        stall_enable = 1'b0;
        test_sorted_random(40);
        stall_enable = 1'b1;
    endtask

    // result checking
    always @(posedge aclk) begin
        search_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[4:1], m_tdata[20:5]};
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.idx !== want.idx ||
                    got.value !== want.value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected f=%0d i=%0d v=%0d got f=%0d i=%0d v=%0d",
                                 want.found, want.idx, want.value,
                                 got.found, got.idx, got.value);
                end
                if (want.found) hit_count++;
            end
        end
    end

    // result-side stalls
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            gap = (stall_enable && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_sorted_random(280);
        test_pause();
        test_sorted_random(280);
        drain_results();
        repeat (600) @(posedge aclk);
        $display("%0d searches sent, %0d results seen, %0d hits", search_count,
                 result_count, hit_count);
        $display("covered sorted, flat and unsorted tables with stalls on both sides");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end
endmodule
